>>> rtl/start_field_order_parser_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef START_FIELD_ORDER_PARSER_MACROS_SVH
`define START_FIELD_ORDER_PARSER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define SFOP_ASSERT_SAME(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define SFOP_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error(msg);

`else

`define SFOP_ASSERT_SAME(lbl, clk_sig, rstn_sig, ante, cons, msg)
`define SFOP_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons, msg)

`endif

`endif

>>> rtl/sfop_pkg.sv
`default_nettype none

package sfop_pkg;

    // Order framing constants
    localparam logic [7:0]  SF_CODE   = 8'h1D;
    localparam logic [7:0]  ATTR_MASK = 8'hE0;
    localparam logic [7:0]  ATTR_TAG  = 8'h20;
    localparam logic [15:0] MIN_LEN   = 16'd5;

    // Byte roles
    localparam logic [3:0] ROLE_CODE     = 4'd0;
    localparam logic [3:0] ROLE_FFW1     = 4'd1;
    localparam logic [3:0] ROLE_FFW2     = 4'd2;
    localparam logic [3:0] ROLE_FCW_HIGH = 4'd3;
    localparam logic [3:0] ROLE_FCW_LOW  = 4'd4;
    localparam logic [3:0] ROLE_ATTR     = 4'd5;
    localparam logic [3:0] ROLE_LEN_HIGH = 4'd6;
    localparam logic [3:0] ROLE_LEN_LOW  = 4'd7;
    localparam logic [3:0] ROLE_DATA     = 4'd8;
    localparam logic [3:0] ROLE_BEYOND   = 4'd9;

    // Final status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
    localparam logic [2:0] ST_BAD_CODE   = 3'd2;
    localparam logic [2:0] ST_TRUNC_ATTR = 3'd3;
    localparam logic [2:0] ST_TRUNC_LEN  = 3'd4;

    // Parser phase, one-hot
    typedef enum logic [8:0] {
        PH_CODE        = 9'b000000001,
        PH_FFW1        = 9'b000000010,
        PH_FFW2        = 9'b000000100,
        PH_FCW_OR_ATTR = 9'b000001000,
        PH_FCW_LOW     = 9'b000010000,
        PH_LEN_HI      = 9'b000100000,
        PH_LEN_LO      = 9'b001000000,
        PH_DATA        = 9'b010000000,
        PH_BEYOND      = 9'b100000000
    } phase_t;

    // Result word payload, first field in the high bits
    typedef struct packed {
        logic [15:0] bytes_consumed;
        logic [2:0]  status;
        logic [15:0] field_length;
        logic [15:0] control_word;
        logic [7:0]  byte_value;
        logic [3:0]  byte_role;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/start_field_order_parser.sv
// Start Field order parser.
// Input stream: one word per order byte; tdata holds the byte, tlast marks the
// final byte of the buffer. Output stream: one word per input word, carrying
// the byte's role, the byte itself, the assembled control word and field
// length, and on the final byte (tlast high) the status and bytes consumed.
// Path: a word accepted into the input register passes through the parse logic
// into the result register, from which it is offered on the output.
// Throughput: one word per cycle unless the output stalls; the parse state is a
// single one-hot phase register plus 16-bit counters updated in the same cycle
// the byte moves from the input register into the result register.
// Reset: both stages empty, parser waits for the order code of a new buffer.
// After every tlast word the parser also returns to that state.
// Output stall: the result register holds its word; the input register still
// takes one more word, and s_axis_tready drops only when both are full.
`default_nettype none

`include "start_field_order_parser_macros.svh"

module start_field_order_parser (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [3:0] byte_role, [11:4] byte_value,
                                        // [27:12] control_word, [43:28] field_length,
                                        // [46:44] status, [62:47] bytes_consumed
    output logic        m_axis_tlast
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    sfop_pkg::result_t out_word_reg;
    logic              out_last_reg;

    logic              advance;
    logic              in_take;
    sfop_pkg::result_t core_result;

    // Move a word from the input register to the result register
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    sfop_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (core_result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= core_result;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_word_reg};
    assign m_axis_tlast  = out_last_reg;

    // An empty input register always takes a word
    `SFOP_ASSERT_SAME(a_empty_ready, clk, rst_n, !in_valid_reg, s_axis_tready, "input stage empty but not ready")
    // A parsed word always lands in the result register
    `SFOP_ASSERT_NEXT(a_advance_lands, clk, rst_n, advance, out_valid_reg, "parsed word lost")
    // A held input word is not dropped while the output stalls
    `SFOP_ASSERT_NEXT(a_hold_input, clk, rst_n, in_valid_reg && !advance, in_valid_reg, "held input word dropped")

endmodule

`default_nettype wire

>>> rtl/sfop_core.sv
`default_nettype none

// Parser state and per-byte decode. State advances only when step_en is high.
module sfop_core (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    step_en,
    input  wire  [7:0]             data_byte,
    input  wire                    last_byte,
    output sfop_pkg::result_t      result
);

    sfop_pkg::phase_t phase_reg, phase_next, phase_calc;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  pend_reg, pend_next, pend_calc;
    logic [15:0] length_reg, length_next, length_calc;
    logic [15:0] remain_reg, remain_next, remain_calc;
    logic [15:0] end_count_reg, end_count_next;
    logic [2:0]  error_reg, error_next, error_calc;

    logic [15:0] byte_count_inc;
    logic [15:0] end_count_inc;
    logic [15:0] remain_dec;
    logic [3:0]  role;
    logic [15:0] cw;
    logic        used;
    logic [2:0]  st;

    assign byte_count_inc = (byte_count_reg == 16'hFFFF) ? byte_count_reg
                                                         : byte_count_reg + 16'd1;
    assign remain_dec = remain_reg - 16'd1;

    // Phase decode for the current byte
    always_comb
    begin
        phase_calc  = phase_reg;
        pend_calc   = pend_reg;
        length_calc = length_reg;
        remain_calc = remain_reg;
        error_calc  = error_reg;
        role        = sfop_pkg::ROLE_BEYOND;
        cw          = 16'd0;
        used        = 1'b1;
        unique case (phase_reg)
            sfop_pkg::PH_CODE:
            begin
                role = sfop_pkg::ROLE_CODE;
                if (data_byte == sfop_pkg::SF_CODE)
                begin
                    phase_calc = sfop_pkg::PH_FFW1;
                end
                else
                begin
                    error_calc = sfop_pkg::ST_BAD_CODE;
                    phase_calc = sfop_pkg::PH_BEYOND;
                end
            end
            sfop_pkg::PH_FFW1:
            begin
                role       = sfop_pkg::ROLE_FFW1;
                phase_calc = sfop_pkg::PH_FFW2;
            end
            sfop_pkg::PH_FFW2:
            begin
                role       = sfop_pkg::ROLE_FFW2;
                phase_calc = sfop_pkg::PH_FCW_OR_ATTR;
                if (last_byte)
                begin
                    error_calc = sfop_pkg::ST_TRUNC_ATTR;
                end
            end
            sfop_pkg::PH_FCW_OR_ATTR:
            begin
                if (!last_byte && ((data_byte & sfop_pkg::ATTR_MASK) != sfop_pkg::ATTR_TAG))
                begin
                    role       = sfop_pkg::ROLE_FCW_HIGH;
                    pend_calc  = data_byte;
                    phase_calc = sfop_pkg::PH_FCW_LOW;
                end
                else
                begin
                    role       = sfop_pkg::ROLE_ATTR;
                    phase_calc = sfop_pkg::PH_LEN_HI;
                    if (last_byte)
                    begin
                        error_calc = sfop_pkg::ST_TRUNC_LEN;
                    end
                end
            end
            sfop_pkg::PH_FCW_LOW:
            begin
                role       = sfop_pkg::ROLE_FCW_LOW;
                cw         = {pend_reg, data_byte};
                phase_calc = sfop_pkg::PH_FCW_OR_ATTR;
                if (last_byte)
                begin
                    error_calc = sfop_pkg::ST_TRUNC_ATTR;
                end
            end
            sfop_pkg::PH_LEN_HI:
            begin
                role       = sfop_pkg::ROLE_LEN_HIGH;
                pend_calc  = data_byte;
                phase_calc = sfop_pkg::PH_LEN_LO;
                if (last_byte)
                begin
                    error_calc = sfop_pkg::ST_TRUNC_LEN;
                end
            end
            sfop_pkg::PH_LEN_LO:
            begin
                role        = sfop_pkg::ROLE_LEN_LOW;
                length_calc = {pend_reg, data_byte};
                remain_calc = {pend_reg, data_byte};
                phase_calc  = ({pend_reg, data_byte} == 16'd0) ? sfop_pkg::PH_BEYOND
                                                               : sfop_pkg::PH_DATA;
            end
            sfop_pkg::PH_DATA:
            begin
                role        = sfop_pkg::ROLE_DATA;
                remain_calc = remain_dec;
                if (remain_dec == 16'd0)
                begin
                    phase_calc = sfop_pkg::PH_BEYOND;
                end
            end
            default:
            begin
                role       = sfop_pkg::ROLE_BEYOND;
                used       = 1'b0;
                phase_calc = sfop_pkg::PH_BEYOND;
            end
        endcase
    end

    // Bytes the order used, saturating
    assign end_count_inc = (!used || end_count_reg == 16'hFFFF) ? end_count_reg
                                                                : end_count_reg + 16'd1;

    // Final status; short buffer wins over any other error
    assign st = (byte_count_inc < sfop_pkg::MIN_LEN) ? sfop_pkg::ST_TOO_SHORT : error_calc;

    always_comb
    begin
        result.byte_role      = role;
        result.byte_value     = data_byte;
        result.control_word   = cw;
        result.field_length   = length_calc;
        result.status         = last_byte ? st : sfop_pkg::ST_OK;
        result.bytes_consumed = (last_byte && st == sfop_pkg::ST_OK) ? end_count_inc : 16'd0;
    end

    // Next state: the last byte of a buffer returns everything to reset
    always_comb
    begin
        if (last_byte)
        begin
            phase_next      = sfop_pkg::PH_CODE;
            byte_count_next = 16'd0;
            pend_next       = 8'd0;
            length_next     = 16'd0;
            remain_next     = 16'd0;
            end_count_next  = 16'd0;
            error_next      = sfop_pkg::ST_OK;
        end
        else
        begin
            phase_next      = phase_calc;
            byte_count_next = byte_count_inc;
            pend_next       = pend_calc;
            length_next     = length_calc;
            remain_next     = remain_calc;
            end_count_next  = end_count_inc;
            error_next      = error_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= sfop_pkg::PH_CODE;
            byte_count_reg <= 16'd0;
            pend_reg       <= 8'd0;
            length_reg     <= 16'd0;
            remain_reg     <= 16'd0;
            end_count_reg  <= 16'd0;
            error_reg      <= sfop_pkg::ST_OK;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            pend_reg       <= pend_next;
            length_reg     <= length_next;
            remain_reg     <= remain_next;
            end_count_reg  <= end_count_next;
            error_reg      <= error_next;
        end
    end

endmodule

`default_nettype wire

>>> sim/tb_start_field_order_parser.sv
`default_nettype none

module tb_start_field_order_parser;
    import sfop_pkg::*;

    // One input byte waiting to be offered, with the idle cycles before it
    typedef struct {
        logic [7:0] value;
        logic       is_last;
        int         gap;
        bit         quiet;
    } order_byte_t;

    // Expected output word
    typedef struct packed {
        logic    finished;
        result_t word;
    } parsed_byte_t;

    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTED = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;           // [3:0] role, [11:4] byte, [27:12] control word,
                                         // [43:28] length, [46:44] status, [62:47] consumed
    logic        m_axis_tlast;

    order_byte_t  pending_bytes[$];
    parsed_byte_t expected_words[$];

    // Parser state as predicted
    phase_t      ph = PH_CODE;
    logic [15:0] seen_count = '0;
    logic [7:0]  held_byte = '0;
    logic [15:0] field_len = '0;
    logic [15:0] data_left = '0;
    logic [15:0] used_count = '0;
    logic [2:0]  err_code = ST_OK;

    int  n_queued = 0;
    int  n_accepted = 0;
    int  n_results = 0;
    int  n_errors = 0;
    int  cycle_count = 0;
    int  cycle_limit = 2000000;
    int  stall_left = 0;
    int  tx_run_left = 0;
    bit  tx_busy = 1'b1;
    bit  in_taken = 1'b0;
    bit  out_taken = 1'b0;
    bit  cur_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    order_byte_t  next_byte;
    result_t      got_word;
    parsed_byte_t want;

    start_field_order_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sender idle: runs of busy items with random gaps, and runs with none
    function automatic int draw_tx_gap();
        if (tx_run_left == 0)
        begin
            tx_run_left = $urandom_range(8, 40);
            tx_busy     = ($urandom_range(0, 2) != 0);
        end
        tx_run_left--;
        return tx_busy ? $urandom_range(0, 19) : 0;
    endfunction

    // Receiver stall: every third block of 64 words goes without stalls
    function automatic int draw_rx_stall();
        if (rx_quiet || ((n_results / 64) % 3 == 0))
            return 0;
        return $urandom_range(0, 19);
    endfunction

    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("mismatch at cycle %0d, word %0d: %s", cycle_count, n_results, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] exp_val);
        if (got !== exp_val)
            flag_error($sformatf("%s got %h expected %h", name, got, exp_val));
    endtask

    task automatic push_byte(input logic [7:0] value, input logic is_last, input bit quiet);
        order_byte_t ob;
        ob.value   = value;
        ob.is_last = is_last;
        ob.gap     = quiet ? 0 : draw_tx_gap();
        ob.quiet   = quiet;
        pending_bytes.insert(pending_bytes.size(), ob);
        n_queued++;
    endtask

    // Directed buffer, bytes listed first to last from the top of the vector
    task automatic queue_hex(input logic [127:0] bytes, input int n);
        for (int i = 0; i < n; i++)
            push_byte(bytes[8*(n-1-i) +: 8], i == n - 1, 1'b0);
    endtask

    task automatic queue_noise(input int n);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom), i == n - 1, 1'b0);
    endtask

    // Start Field order with random content, optionally cut short after keep bytes
    task automatic queue_order(input bit bad_code, input int n_fcw, input logic [15:0] len,
                               input int n_data, input int n_extra, input int keep,
                               input bit quiet);
        logic [7:0] bytes_q[$];
        logic [7:0] v;
        int total;
        if (bad_code)
        begin
            do v = 8'($urandom); while (v == SF_CODE);
            bytes_q.insert(bytes_q.size(), v);
        end
        else
            bytes_q.insert(bytes_q.size(), SF_CODE);
        bytes_q.insert(bytes_q.size(), 8'($urandom));
        bytes_q.insert(bytes_q.size(), 8'($urandom));
        for (int i = 0; i < n_fcw; i++)
        begin
            do v = 8'($urandom); while ((v & ATTR_MASK) == ATTR_TAG);
            bytes_q.insert(bytes_q.size(), v);
            bytes_q.insert(bytes_q.size(), 8'($urandom));
        end
        bytes_q.insert(bytes_q.size(), ATTR_TAG | (8'($urandom) & ~ATTR_MASK));
        bytes_q.insert(bytes_q.size(), len[15:8]);
        bytes_q.insert(bytes_q.size(), len[7:0]);
        for (int i = 0; i < n_data + n_extra; i++)
            bytes_q.insert(bytes_q.size(), 8'($urandom));
        total = (keep > 0 && keep < bytes_q.size()) ? keep : bytes_q.size();
        for (int i = 0; i < total; i++)
            push_byte(bytes_q[i], i == total - 1, quiet);
    endtask

    task automatic clear_parser();
        ph         = PH_CODE;
        seen_count = '0;
        held_byte  = '0;
        field_len  = '0;
        data_left  = '0;
        used_count = '0;
        err_code   = ST_OK;
    endtask

    // Predict the word for one accepted byte and advance the parser
    task automatic parse_byte(input logic [7:0] b, input logic is_last);
        parsed_byte_t e;
        logic used;
        logic [2:0] st;
        e = '0;
        used = 1'b1;
        e.word.byte_role  = ROLE_BEYOND;
        e.word.byte_value = b;
        if (seen_count != 16'hFFFF)
            seen_count++;
        case (ph)
            PH_CODE:
            begin
                e.word.byte_role = ROLE_CODE;
                if (b == SF_CODE)
                    ph = PH_FFW1;
                else
                begin
                    err_code = ST_BAD_CODE;
                    ph = PH_BEYOND;
                end
            end
            PH_FFW1:
            begin
                e.word.byte_role = ROLE_FFW1;
                ph = PH_FFW2;
            end
            PH_FFW2:
            begin
                e.word.byte_role = ROLE_FFW2;
                ph = PH_FCW_OR_ATTR;
                if (is_last)
                    err_code = ST_TRUNC_ATTR;
            end
            PH_FCW_OR_ATTR:
            begin
                // control word only if a second byte can follow
                if (!is_last && ((b & ATTR_MASK) != ATTR_TAG))
                begin
                    e.word.byte_role = ROLE_FCW_HIGH;
                    held_byte = b;
                    ph = PH_FCW_LOW;
                end
                else
                begin
                    e.word.byte_role = ROLE_ATTR;
                    ph = PH_LEN_HI;
                    if (is_last)
                        err_code = ST_TRUNC_LEN;
                end
            end
            PH_FCW_LOW:
            begin
                e.word.byte_role    = ROLE_FCW_LOW;
                e.word.control_word = {held_byte, b};
                ph = PH_FCW_OR_ATTR;
                if (is_last)
                    err_code = ST_TRUNC_ATTR;
            end
            PH_LEN_HI:
            begin
                e.word.byte_role = ROLE_LEN_HIGH;
                held_byte = b;
                ph = PH_LEN_LO;
                if (is_last)
                    err_code = ST_TRUNC_LEN;
            end
            PH_LEN_LO:
            begin
                e.word.byte_role = ROLE_LEN_LOW;
                field_len = {held_byte, b};
                data_left = field_len;
                ph = (field_len == 16'd0) ? PH_BEYOND : PH_DATA;
            end
            PH_DATA:
            begin
                e.word.byte_role = ROLE_DATA;
                data_left = data_left - 16'd1;
                if (data_left == 16'd0)
                    ph = PH_BEYOND;
            end
            default:
            begin
                used = 1'b0;
                ph = PH_BEYOND;
            end
        endcase
        if (used && used_count != 16'hFFFF)
            used_count++;
        e.word.field_length = field_len;
        e.finished = is_last;
        if (is_last)
        begin
            // short buffer wins over every other error
            st = (seen_count < MIN_LEN) ? ST_TOO_SHORT : err_code;
            e.word.status = st;
            e.word.bytes_consumed = (st == ST_OK) ? used_count : 16'd0;
            clear_parser();
        end
        expected_words.insert(expected_words.size(), e);
    endtask

    // Input side: predict on every accepted word
    always @(posedge clk)
    begin
        in_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken)
        begin
            parse_byte(s_axis_tdata, s_axis_tlast);
            rx_quiet = cur_quiet;
            n_accepted++;
        end
    end

    // Driver: hold the word until taken, then wait out the next gap
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!(s_axis_tvalid && !in_taken))
        begin
            if (pending_bytes.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (pending_bytes[0].gap > 0)
            begin
                pending_bytes[0].gap = pending_bytes[0].gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                next_byte = pending_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_byte.value;
                s_axis_tlast  <= next_byte.is_last;
                cur_quiet = next_byte.quiet;
            end
        end
    end

    // Output side: compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin
        out_taken = rst_n && m_axis_tvalid && m_axis_tready;
        if (out_taken)
        begin
            n_results++;
            got_word = m_axis_tdata[62:0];
            if (expected_words.size() == 0)
                flag_error("output word with nothing expected");
            else
            begin
                want = expected_words.pop_front();
                check_field("byte_role", 16'(got_word.byte_role), 16'(want.word.byte_role));
                check_field("byte_value", 16'(got_word.byte_value), 16'(want.word.byte_value));
                check_field("control_word", got_word.control_word, want.word.control_word);
                check_field("field_length", got_word.field_length, want.word.field_length);
                check_field("finished", 16'(m_axis_tlast), 16'(want.finished));
                check_field("status", 16'(got_word.status), 16'(want.word.status));
                check_field("bytes_consumed", got_word.bytes_consumed,
                            want.word.bytes_consumed);
            end
        end
    end

    // Receiver ready, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (out_taken)
                stall_left = (n_results == HOLD_AT) ? HOLD_CYCLES : draw_rx_stall();
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int sel;
        int n_fcw;
        int n_data;
        int keep;
        logic [15:0] len;

        // short buffer with a good code
        queue_hex(128'h1DFF, 2);
        // wrong order code
        queue_hex(128'h00_1D_20_FF_00, 5);
        // ends right after a control word
        queue_hex(128'h1D_00_FF_E0_FF, 5);
        // last byte forced to attribute though its top bits say control word
        queue_hex(128'h1D_FF_00_00_12_C5, 6);
        // zero length, then a byte beyond the order
        queue_hex(128'h1D_00_00_3F_00_00_AA, 7);
        // data ends early
        queue_hex(128'h1D_12_34_20_00_05_00_FF, 8);

        // length above 255 with all data present
        queue_order(1'b0, 1, 16'h0102, 258, 2, 0, 1'b0);

        while (n_queued < 750)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                queue_noise($urandom_range(1, 12));
            else if (sel == 1)
                queue_order(1'b1, $urandom_range(0, 2), 16'($urandom_range(0, 4)),
                            $urandom_range(0, 4), $urandom_range(0, 2), 0, 1'b0);
            else
            begin
                n_fcw = $urandom_range(0, 3);
                if ($urandom_range(0, 7) == 0)
                    len = {8'($urandom_range(1, 255)), 8'($urandom)};
                else
                    len = 16'($urandom_range(0, 8));
                if (len > 16'd12)
                    n_data = $urandom_range(0, 12);
                else if ($urandom_range(0, 3) == 0)
                    n_data = $urandom_range(0, int'(len));
                else
                    n_data = int'(len);
                keep = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8 + 2 * n_fcw) : 0;
                queue_order(1'b0, n_fcw, len, n_data,
                            ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0,
                            keep, 1'b0);
            end
        end

        cycle_limit = n_queued * 200 + HOLD_CYCLES + 5000;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (n_accepted != n_queued || expected_words.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/sfop_pkg.sv
rtl/sfop_core.sv
rtl/start_field_order_parser.sv
sim/tb_start_field_order_parser.sv
